/* hdl/qn_pkg.sv */
`default_nettype none
package qn_pkg;

  localparam int COMP_BITS = 16;
  localparam int SQ_W      = 2 * COMP_BITS;
  localparam int SUM_W     = SQ_W + 1;
  localparam int V_W       = SUM_W + 16;
  localparam int VE_W      = V_W + (V_W % 2);
  localparam int ROOT_W    = VE_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int UNIT_W    = 16;
  localparam int Q_W       = 15;
  localparam int NORM_W    = 25;
  localparam int FRAC_SH   = 22;
  localparam int DIV_PRE   = FRAC_SH - Q_W;
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] comp_w;
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
  } src_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_w;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic [NORM_W-1:0]        norm_scaled;
    logic                     zero_norm;
  } res_t;

  // per-item sideband carried alongside the root pipeline
  typedef struct packed {
    logic [NUM_LANES-1:0][COMP_BITS-1:0] mag;
    logic [NUM_LANES-1:0]                neg;
    logic                                zero;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [VE_W-1:0]   v;
  } sq_t;

  // one digit pair of the restoring square root
  function automatic sq_t sqrt_step(sq_t s);
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] tr;
    sq_t o;
    rs = {s.rem[REM_W-3:0], s.v[VE_W-1 -: 2]};
    tr = {s.root, 2'b01};
    o.v = s.v << 2;
    if (rs >= tr) begin
      o.rem  = rs - tr;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* hdl/qn_sqrt.sv */
`default_nettype none
module qn_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qn_pkg::VE_W-1:0]   v,
  input  qn_pkg::side_t             side_in,
  output logic [qn_pkg::ROOT_W-1:0] root,
  output qn_pkg::side_t             side_out
);
  import qn_pkg::*;

  sq_t   st  [ROOT_W];
  sq_t   cur [ROOT_W];
  side_t sd  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        cur[k] = sqrt_step('{rem: '0, root: '0, v: v});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          st[k] <= cur[k];
          sd[k] <= side_in;
        end
      end
    end else begin : g_next
      always_comb begin
        cur[k] = sqrt_step(st[k-1]);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          st[k] <= cur[k];
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  assign root     = st[ROOT_W-1].root;
  assign side_out = sd[ROOT_W-1];

endmodule
`default_nettype wire

/* hdl/qn_div_lane.sv */
`default_nettype none
module qn_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qn_pkg::COMP_BITS-1:0] mag,
  input  logic                         neg,
  input  logic [qn_pkg::ROOT_W-1:0]    divisor,
  output logic [qn_pkg::Q_W-1:0]       quot,
  output logic                         quot_neg
);
  import qn_pkg::*;

  logic [ROOT_W-1:0] rem [Q_W];
  logic [ROOT_W-1:0] dv  [Q_W];
  logic [Q_W-1:0]    q   [Q_W];
  logic              ng  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [ROOT_W-1:0] rem_in;
    logic [ROOT_W-1:0] dv_in;
    logic [Q_W-1:0]    q_in;
    logic              ng_in;
    logic [ROOT_W:0]   rs;
    if (k == 0) begin : g_first
      // low dividend bits are all zero, so start from the top part
      assign rem_in = ROOT_W'(mag) << DIV_PRE;
      assign dv_in  = divisor;
      assign q_in   = '0;
      assign ng_in  = neg;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign dv_in  = dv[k-1];
      assign q_in   = q[k-1];
      assign ng_in  = ng[k-1];
    end
    assign rs = {rem_in, 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= dv_in;
        ng[k] <= ng_in;
        if (rs >= {1'b0, dv_in}) begin
          rem[k] <= ROOT_W'(rs - {1'b0, dv_in});
          q[k]   <= {q_in[Q_W-2:0], 1'b1};
        end else begin
          rem[k] <= rs[ROOT_W-1:0];
          q[k]   <= {q_in[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quot     = q[Q_W-1];
  assign quot_neg = ng[Q_W-1];

endmodule
`default_nettype wire

/* hdl/quaternion_normalize.sv */
`default_nettype none
// Pipeline: 43 register stages: stage A, stage B, the root stages, the divider stages
// and the merge register that holds the output.
// Throughput: one item per cycle unless the output stalls; the root takes one digit pair
// per stage and the four divider lanes one quotient bit per stage, all fully pipelined.
// Reset: rst (synchronous, active high) clears every valid flag; data stages
// are not reset.
module quaternion_normalize (
  input  logic         clk,
  input  logic         rst,
  input  logic         src_valid,
  output logic         src_ready,
  input  qn_pkg::src_t src,
  output logic         res_valid,
  input  logic         res_ready,
  output qn_pkg::res_t res
);
  import qn_pkg::*;

  localparam int DEPTH = 2 + ROOT_W + Q_W;

  logic              en;
  logic [DEPTH-1:0]  vld;

  logic [COMP_BITS-1:0] comp [NUM_LANES];
  logic [COMP_BITS-1:0] m    [NUM_LANES];
  logic [SQ_W-1:0]      sq   [NUM_LANES];
  side_t                side_a;
  side_t                side_b;
  logic [VE_W-1:0]      v_b;
  logic [SUM_W-1:0]     sum;

  logic [ROOT_W-1:0]    root;
  side_t                side_r;

  logic [Q_W-1:0]       quot     [NUM_LANES];
  logic                 quot_neg [NUM_LANES];
  logic [ROOT_W-1:0]    norm_d   [Q_W];
  logic                 zero_d   [Q_W];
  logic [UNIT_W-1:0]    unit     [NUM_LANES];

  // advance the whole pipe whenever the output register is free or being taken
  assign en        = !res_valid || res_ready;
  assign src_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[DEPTH-2:0], src_valid};
      res_valid <= vld[DEPTH-1];
    end
  end

  assign comp[0] = src.comp_w;
  assign comp[1] = src.comp_x;
  assign comp[2] = src.comp_y;
  assign comp[3] = src.comp_z;

  // stage A: magnitudes and squares, one multiplier per lane
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_mag
    // the most negative value maps onto its own bit pattern, read as unsigned
    assign m[i] = comp[i][COMP_BITS-1] ? COMP_BITS'(-comp[i]) : comp[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        sq[i]         <= SQ_W'(m[i]) * SQ_W'(m[i]);
        side_a.mag[i] <= m[i];
        side_a.neg[i] <= comp[i][COMP_BITS-1];
      end
      side_a.zero <= 1'b0;
    end
  end

  // stage B: sum of squares, scaled by 2^16 ahead of the root
  assign sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      v_b         <= VE_W'({sum, 16'h0000});
      side_b.mag  <= side_a.mag;
      side_b.neg  <= side_a.neg;
      side_b.zero <= (sum == '0);
    end
  end

  qn_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .v        (v_b),
    .side_in  (side_b),
    .root     (root),
    .side_out (side_r)
  );

  // four divider lanes side by side, all by the same root
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    qn_div_lane u_lane (
      .clk      (clk),
      .en       (en),
      .mag      (side_r.mag[i]),
      .neg      (side_r.neg[i]),
      .divisor  (root),
      .quot     (quot[i]),
      .quot_neg (quot_neg[i])
    );
    assign unit[i] = quot_neg[i] ? UNIT_W'(-{1'b0, quot[i]}) : UNIT_W'({1'b0, quot[i]});
  end

  // hold the norm and zero flag level with the divider lanes
  for (genvar k = 0; k < Q_W; k++) begin : g_dly
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          norm_d[k] <= root;
          zero_d[k] <= side_r.zero;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          norm_d[k] <= norm_d[k-1];
          zero_d[k] <= zero_d[k-1];
        end
      end
    end
  end

  // merge: gather the lanes; for an all-zero item drop units and norm to zero and set zero_norm
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_d[Q_W-1]) begin
        res <= '{unit_w: '0, unit_x: '0, unit_y: '0, unit_z: '0,
                 norm_scaled: '0, zero_norm: 1'b1};
      end else begin
        res <= '{unit_w: unit[0], unit_x: unit[1], unit_y: unit[2], unit_z: unit[3],
                 norm_scaled: NORM_W'(norm_d[Q_W-1]), zero_norm: 1'b0};
      end
    end
  end

`ifndef ASSERT_OFF
  a_ready: assert property (@(posedge clk) disable iff (rst)
    src_ready == (!res_valid || res_ready))
    else $error("input ready does not follow the output register");
  a_norm: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.zero_norm |-> res.norm_scaled != '0)
    else $error("nonzero item gave a zero norm");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.zero_norm |-> res.unit_w == '0 && res.unit_x == '0 &&
      res.unit_y == '0 && res.unit_z == '0)
    else $error("zero item gave nonzero components");
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.unit_w >= -16'sd16384 && res.unit_w <= 16'sd16384)
    else $error("unit component out of range");
`endif

endmodule
`default_nettype wire
